@@ design/cbf_pkg.sv @@
// Shared types and constants for the cubic Bezier flattener.
`timescale 1ns / 1ps

package cbf_pkg;

   localparam int SEG_BITS = 6;
   localparam int T_BITS   = 17;
   localparam int W_BITS   = 19;
   localparam int BIT_CNT_BITS = 5;

   localparam logic [T_BITS-1:0]   T_ONE     = 17'h10000;
   localparam logic [SEG_BITS-1:0] SEG_RESET = 6'd16;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef enum logic {
      DIV_BUSY,
      DIV_DONE
   } div_state_type;

   // step of t per sample: T_ONE / segments, quotient and remainder
   typedef struct packed {
      logic                ready;
      logic [T_BITS-1:0]   quot;
      logic [SEG_BITS-1:0] rem;
   } step_type;

endpackage

@@ design/cbf_step_div.sv @@
// Bit-serial divider that derives the t step from the segment count.
`timescale 1ns / 1ps

module cbf_step_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cbf_pkg::SEG_BITS-1:0] divisor,
   output cbf_pkg::step_type          step
);
   import cbf_pkg::*;

   div_state_type           state_ff, state_in;
   logic [BIT_CNT_BITS-1:0] bit_ff;
   logic [T_BITS-1:0]       quot_ff;
   logic [SEG_BITS-1:0]     rem_ff;

   logic                    dvd_bit;
   logic [SEG_BITS:0]       rem_sh;
   logic [SEG_BITS:0]       rem_diff;
   logic                    fits;

   // the dividend is T_ONE: only its top bit is set
   assign dvd_bit  = (bit_ff == BIT_CNT_BITS'(T_BITS - 1));
   assign rem_sh   = {rem_ff, dvd_bit};
   assign rem_diff = rem_sh - {1'b0, divisor};
   assign fits     = (rem_sh >= {1'b0, divisor});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DIV_BUSY: begin
            if (bit_ff == '0) state_in = DIV_DONE;
         end
         DIV_DONE: begin
            state_in = DIV_DONE;
         end
         default: begin
            state_in = DIV_BUSY;
         end
      endcase
      if (start) state_in = DIV_BUSY;
   end

   always_comb begin
      step.ready = (state_ff == DIV_DONE);
      step.quot  = quot_ff;
      step.rem   = rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         state_ff <= DIV_BUSY;
         bit_ff   <= BIT_CNT_BITS'(T_BITS - 1);
         quot_ff  <= '0;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == DIV_BUSY) begin
            quot_ff <= {quot_ff[T_BITS-2:0], fits};
            rem_ff  <= fits ? rem_diff[SEG_BITS-1:0] : rem_sh[SEG_BITS-1:0];
            bit_ff  <= bit_ff - 1'b1;
         end
      end
   end

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == DIV_DONE |-> rem_ff < divisor)
      else $error("step remainder not below segment count");

   a_div_identity: assert property (@(posedge clock) disable iff (reset)
      state_ff == DIV_DONE |->
         (24'(quot_ff) * 24'(divisor) + 24'(rem_ff)) == 24'(T_ONE))
      else $error("step quotient and remainder do not rebuild one");

   a_div_finishes: assert property (@(posedge clock) disable iff (reset)
      state_ff == DIV_BUSY && bit_ff == '0 && !start |=> state_ff == DIV_DONE)
      else $error("divider did not finish after last bit");

endmodule

@@ design/cubic_bezier_flattener_unit.sv @@
// Top level: cubic Bezier flattener with sample sequencer and weight/point pipeline.
//
// channel  | direction | handshake              | contents
// req_     | in        | req_tvalid/req_tready  | four control points (x, y each)
// rsp_     | out       | rsp_tvalid/rsp_tready  | point x, y, index; tlast on last point
// csr_     | in        | csr_wr_en              | segment count
//
// An item issues segments+1 samples, one per cycle while the output is taken; the sample
// sequencer is the limit, and it passes through its idle state to take each item. A
// point's sample passes through the t, squares, weights, terms and output word stage
// registers before the point leaves; the next item can be taken in the cycle after the
// previous one's last sample is issued. After reset and after each csr write the step
// divider runs, and no item is taken until it is done. A stall on rsp_ freezes the whole
// pipeline in place; nothing is dropped or repeated.
`timescale 1ns / 1ps

module cubic_bezier_flattener_unit #(
   parameter int COORD_BITS   = 24,
   parameter int FRAC_BITS    = 8,
   parameter int MAX_SEGMENTS = 63
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
   input  logic [8*COORD_BITS-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // point_x, point_y, point_index, zero pad
   output logic [((2*COORD_BITS+cbf_pkg::SEG_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tlast,
   input  logic csr_wr_en,
   input  logic [cbf_pkg::SEG_BITS-1:0] csr_wr_data
);
   import cbf_pkg::*;

   localparam int TW    = COORD_BITS + W_BITS + 1;
   localparam int SHIFT = 16 - FRAC_BITS;
   localparam int OUT_W = 2 * COORD_BITS + SEG_BITS;

   // configuration and step
   logic [SEG_BITS-1:0] segments_ff;
   logic [SEG_BITS-1:0] segs_eff;
   step_type            step;

   // sequencer
   seq_state_type       seq_state_ff, seq_state_in;
   logic [SEG_BITS-1:0] idx_ff, idx_in;
   logic [T_BITS-1:0]   t_ff, t_in;
   logic [SEG_BITS-1:0] frac_ff, frac_in;
   logic [SEG_BITS:0]   frac_sum;
   logic                frac_wrap;
   logic signed [COORD_BITS-1:0] pt_ff [8];
   logic signed [COORD_BITS-1:0] req_pt [8];
   logic                req_acc;
   logic                issue;
   logic                seq_last;
   logic                adv;

   // stage 1: t and 1-t
   logic                s1_valid_ff;
   logic [T_BITS-1:0]   s1_t_ff, s1_omt_ff;
   logic [SEG_BITS-1:0] s1_idx_ff;
   logic                s1_last_ff;
   logic signed [COORD_BITS-1:0] s1_pt_ff [8];

   // stage 2: squares
   logic                s2_valid_ff;
   logic [T_BITS-1:0]   s2_t_ff, s2_omt_ff, s2_o2_ff, s2_t2_ff;
   logic [SEG_BITS-1:0] s2_idx_ff;
   logic                s2_last_ff;
   logic signed [COORD_BITS-1:0] s2_pt_ff [8];
   logic [2*T_BITS-1:0] m_oo, m_tt;

   // stage 3: weights
   logic                s3_valid_ff;
   logic [W_BITS-1:0]   s3_w_ff [4];
   logic [W_BITS-1:0]   w_in [4];
   logic [SEG_BITS-1:0] s3_idx_ff;
   logic                s3_last_ff;
   logic signed [COORD_BITS-1:0] s3_pt_ff [8];
   logic [2*T_BITS-1:0] m_o3, m_ot, m_mt, m_t3;

   // stage 4: weighted terms
   logic                s4_valid_ff;
   logic signed [TW-1:0] s4_term_ff [8];
   logic signed [TW-1:0] prod [8];
   logic [SEG_BITS-1:0] s4_idx_ff;
   logic                s4_last_ff;

   // stage 5: output word
   logic                s5_valid_ff;
   logic [COORD_BITS-1:0] s5_x_ff, s5_y_ff;
   logic [SEG_BITS-1:0] s5_idx_ff;
   logic                s5_last_ff;
   logic signed [TW-1:0] sum_x, sum_y;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         segments_ff <= SEG_RESET;
      end else if (csr_wr_en) begin
         segments_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (segments_ff == '0) begin
         segs_eff = SEG_BITS'(1);
      end else if (segments_ff > SEG_BITS'(MAX_SEGMENTS)) begin
         segs_eff = SEG_BITS'(MAX_SEGMENTS);
      end else begin
         segs_eff = segments_ff;
      end
   end

   cbf_step_div u_step_div (
      .clock   (clock),
      .reset   (reset),
      .start   (csr_wr_en),
      .divisor (segs_eff),
      .step    (step)
   );

   // ---------------------------------------------------------------- sequencer
   assign adv      = !s5_valid_ff || rsp_tready;
   assign req_acc  = req_tvalid && req_tready;
   assign seq_last = (idx_ff == segs_eff);

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         req_pt[k] = req_tdata[k*COORD_BITS +: COORD_BITS];
      end
   end

   always_comb begin
      seq_state_in = seq_state_ff;
      case (seq_state_ff)
         SEQ_IDLE: begin
            if (req_acc) seq_state_in = SEQ_RUN;
         end
         SEQ_RUN: begin
            if (adv && seq_last) seq_state_in = SEQ_IDLE;
         end
         default: begin
            seq_state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = (seq_state_ff == SEQ_IDLE) && step.ready;
      issue      = (seq_state_ff == SEQ_RUN) && adv;
   end

   // t advances by quotient, plus one whenever the remainder share wraps
   always_comb begin
      frac_sum  = {1'b0, frac_ff} + {1'b0, step.rem};
      frac_wrap = (frac_sum >= {1'b0, segs_eff});
      frac_in   = frac_wrap ? SEG_BITS'(frac_sum - {1'b0, segs_eff})
                            : frac_sum[SEG_BITS-1:0];
      t_in      = t_ff + step.quot + T_BITS'(frac_wrap);
      idx_in    = idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff <= SEQ_IDLE;
      end else begin
         seq_state_ff <= seq_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         idx_ff  <= '0;
         t_ff    <= '0;
         frac_ff <= '0;
         pt_ff   <= req_pt;
      end else if (issue && !seq_last) begin
         idx_ff  <= idx_in;
         t_ff    <= t_in;
         frac_ff <= frac_in;
      end
   end

   // ---------------------------------------------------------------- pipeline
   assign m_oo = (2*T_BITS)'(s1_omt_ff) * (2*T_BITS)'(s1_omt_ff);
   assign m_tt = (2*T_BITS)'(s1_t_ff) * (2*T_BITS)'(s1_t_ff);

   assign m_o3 = (2*T_BITS)'(s2_o2_ff) * (2*T_BITS)'(s2_omt_ff);
   assign m_ot = (2*T_BITS)'(s2_o2_ff) * (2*T_BITS)'(s2_t_ff);
   assign m_mt = (2*T_BITS)'(s2_omt_ff) * (2*T_BITS)'(s2_t2_ff);
   assign m_t3 = (2*T_BITS)'(s2_t2_ff) * (2*T_BITS)'(s2_t_ff);

   always_comb begin
      w_in[0] = W_BITS'(m_o3[T_BITS+15:16]);
      w_in[1] = (W_BITS'(m_ot[T_BITS+15:16]) << 1) + W_BITS'(m_ot[T_BITS+15:16]);
      w_in[2] = (W_BITS'(m_mt[T_BITS+15:16]) << 1) + W_BITS'(m_mt[T_BITS+15:16]);
      w_in[3] = W_BITS'(m_t3[T_BITS+15:16]);
   end

   // floor each term to 16 fraction bits
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         prod[k] = TW'(s3_pt_ff[k]) * TW'(signed'({1'b0, s3_w_ff[k >> 1]}));
      end
   end

   always_comb begin
      sum_x = s4_term_ff[0] + s4_term_ff[2] + s4_term_ff[4] + s4_term_ff[6];
      sum_y = s4_term_ff[1] + s4_term_ff[3] + s4_term_ff[5] + s4_term_ff[7];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_t_ff    <= t_ff;
         s1_omt_ff  <= T_ONE - t_ff;
         s1_idx_ff  <= idx_ff;
         s1_last_ff <= seq_last;
         s1_pt_ff   <= pt_ff;

         s2_t_ff    <= s1_t_ff;
         s2_omt_ff  <= s1_omt_ff;
         s2_o2_ff   <= m_oo[T_BITS+15:16];
         s2_t2_ff   <= m_tt[T_BITS+15:16];
         s2_idx_ff  <= s1_idx_ff;
         s2_last_ff <= s1_last_ff;
         s2_pt_ff   <= s1_pt_ff;

         s3_w_ff    <= w_in;
         s3_idx_ff  <= s2_idx_ff;
         s3_last_ff <= s2_last_ff;
         s3_pt_ff   <= s2_pt_ff;

         for (int k = 0; k < 8; k++) begin
            s4_term_ff[k] <= prod[k] >>> FRAC_BITS;
         end
         s4_idx_ff  <= s3_idx_ff;
         s4_last_ff <= s3_last_ff;

         s5_x_ff    <= sum_x[SHIFT +: COORD_BITS];
         s5_y_ff    <= sum_y[SHIFT +: COORD_BITS];
         s5_idx_ff  <= s4_idx_ff;
         s5_last_ff <= s4_last_ff;
      end
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      rsp_tvalid = s5_valid_ff;
      rsp_tlast  = s5_last_ff;
      rsp_tdata  = '0;
      rsp_tdata[OUT_W-1:0] = {s5_idx_ff, s5_y_ff, s5_x_ff};
   end

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      issue && seq_last |=> seq_state_ff == SEQ_IDLE)
      else $error("sequencer kept running after last sample");

   a_accept_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> seq_state_ff == SEQ_RUN && idx_ff == '0 && t_ff == '0)
      else $error("new item did not start at t zero");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && adv |=> s2_valid_ff)
      else $error("sample lost between first and second stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && !adv |=> s4_valid_ff)
      else $error("term stage dropped a word during stall");

endmodule
